### design/vvp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Vertex view projection package
// Shared widths, payload words, register indexes and the sine table.
// ----------------------------------------------------------------------------
package vvp_pkg;

  // Field and datapath widths.
  localparam int unsigned COORD_W   = 32;  // Q16.16 coordinates
  localparam int unsigned POS_W     = 33;  // world minus camera, exact
  localparam int unsigned TRIG_W    = 16;  // Q1.14 sine and cosine
  localparam int unsigned PROD_W    = 54;  // product sums before rounding
  localparam int unsigned MID_W     = 36;  // first and second rotation stage
  localparam int unsigned ROT_W     = 38;  // last rotation stage
  localparam int unsigned DEPTH_W   = 31;  // near, far and divisor depth
  localparam int unsigned ANG_W     = 9;   // angles in whole degrees
  localparam int unsigned FOCAL_W   = 32;  // focal scale, unsigned Q16.16
  localparam int unsigned NUM_W     = 70;  // magnitude times focal scale
  localparam int unsigned QUO_BITS  = 40;  // quotient bits below saturation
  localparam int unsigned QUO_W     = QUO_BITS + 1;
  localparam int unsigned DIV_BPS   = 2;   // quotient bits per divider stage
  localparam int unsigned DIV_STEPS = QUO_BITS / DIV_BPS;
  localparam int unsigned DIV_LAT   = DIV_STEPS + 2;
  localparam int unsigned CFG_IDX_W = 3;

  // Build defaults of the screen and the field of view.
  localparam int unsigned DEF_SCREEN_W = 80;
  localparam int unsigned DEF_SCREEN_H = 24;
  localparam int unsigned DEF_FOV_DEG  = 60;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CAM_POS_X   = 3'd0,
    CFG_CAM_POS_Y   = 3'd1,
    CFG_CAM_POS_Z   = 3'd2,
    CFG_CAM_ANGLE_X = 3'd3,
    CFG_CAM_ANGLE_Y = 3'd4,
    CFG_CAM_ANGLE_Z = 3'd5,
    CFG_NEAR_DEPTH  = 3'd6,
    CFG_FAR_DEPTH   = 3'd7
  } cfg_idx_e;

  // Input word: one world-space point.
  typedef struct packed {
    logic signed [COORD_W-1:0] world_x;
    logic signed [COORD_W-1:0] world_y;
    logic signed [COORD_W-1:0] world_z;
  } in_word_t;

  // Output word: one projected point.
  typedef struct packed {
    logic                      visible;
    logic signed [COORD_W-1:0] screen_x;
    logic signed [COORD_W-1:0] screen_y;
  } out_word_t;

  // First quadrant of sine in Q1.14, one entry per degree.
  localparam logic [14:0] SIN_QUARTER [0:90] = '{
    15'd0,     15'd286,   15'd572,   15'd857,   15'd1143,  15'd1428,  15'd1713,
    15'd1997,  15'd2280,  15'd2563,  15'd2845,  15'd3126,  15'd3406,  15'd3686,
    15'd3964,  15'd4240,  15'd4516,  15'd4790,  15'd5063,  15'd5334,  15'd5604,
    15'd5872,  15'd6138,  15'd6402,  15'd6664,  15'd6924,  15'd7182,  15'd7438,
    15'd7692,  15'd7943,  15'd8192,  15'd8438,  15'd8682,  15'd8923,  15'd9162,
    15'd9397,  15'd9630,  15'd9860,  15'd10087, 15'd10311, 15'd10531, 15'd10749,
    15'd10963, 15'd11174, 15'd11381, 15'd11585, 15'd11786, 15'd11982, 15'd12176,
    15'd12365, 15'd12551, 15'd12733, 15'd12911, 15'd13085, 15'd13255, 15'd13421,
    15'd13583, 15'd13741, 15'd13894, 15'd14044, 15'd14189, 15'd14330, 15'd14466,
    15'd14598, 15'd14726, 15'd14849, 15'd14968, 15'd15082, 15'd15191, 15'd15296,
    15'd15396, 15'd15491, 15'd15582, 15'd15668, 15'd15749, 15'd15826, 15'd15897,
    15'd15964, 15'd16026, 15'd16083, 15'd16135, 15'd16182, 15'd16225, 15'd16262,
    15'd16294, 15'd16322, 15'd16344, 15'd16362, 15'd16374, 15'd16382, 15'd16384
  };

  // Sine of an angle below 720 degrees, folded onto the first quadrant.
  function automatic logic signed [TRIG_W-1:0] sin_deg(input logic [9:0] ang);
    logic [9:0]              am;
    logic [6:0]              idx;
    logic                    neg;
    logic signed [TRIG_W-1:0] mag;
    am = (ang >= 10'd360) ? ang - 10'd360 : ang;
    if (am < 10'd90) begin
      idx = am[6:0];
      neg = 1'b0;
    end else if (am < 10'd180) begin
      idx = 7'(10'd180 - am);
      neg = 1'b0;
    end else if (am < 10'd270) begin
      idx = 7'(am - 10'd180);
      neg = 1'b1;
    end else begin
      idx = 7'(10'd360 - am);
      neg = 1'b1;
    end
    mag = $signed({1'b0, SIN_QUARTER[idx]});
    return neg ? -mag : mag;
  endfunction

  // Cosine as the sine ninety degrees on.
  function automatic logic signed [TRIG_W-1:0] cos_deg(input logic [ANG_W-1:0] ang);
    logic [9:0] am;
    am = (ang >= 9'd360) ? 10'(ang) - 10'd360 : 10'(ang);
    return sin_deg(am + 10'd90);
  endfunction

endpackage
`default_nettype wire

### design/vertex_view_project_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Vertex view projection unit
// Moves world points into camera space and projects them onto the screen.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid_i / in_stall_o / in_word_i carries one world point
//   per word. Output channel out_valid_o / out_stall_i / out_word_o returns one
//   projected word per input word, in order.
//   Camera position, angles and the near and far depths are written through
//   cfg_we_i / cfg_idx_i / cfg_wdata_i while no word is in flight.
//   One word enters per cycle while the skid register is empty: ten arithmetic
//   stages (camera offset, three multiply and round rounds of the rotation,
//   clipping, focal scaling) feed a 22 stage divider (input register, step
//   stages of two quotient bits each, rounding register); the pipeline moves as one.
//   When the receiver stalls, the finished word holds on the output and the
//   next one lands in a skid register; the input stalls only while that skid
//   register is full, then the pipeline freezes until the output is taken.
//   Reset empties the pipeline and restores the camera registers to their
//   defaults (origin, zero angles, depth range 1.0 to 1000.0).
// ----------------------------------------------------------------------------
module vertex_view_project_unit #(
  parameter int unsigned SCREEN_W = vvp_pkg::DEF_SCREEN_W,
  parameter int unsigned SCREEN_H = vvp_pkg::DEF_SCREEN_H,
  parameter int unsigned FOV_DEG  = vvp_pkg::DEF_FOV_DEG
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [vvp_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [vvp_pkg::COORD_W-1:0]   cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  vvp_pkg::in_word_t             in_word_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output vvp_pkg::out_word_t            out_word_o
);
  import vvp_pkg::*;

  localparam int unsigned TopStages = 10;
  localparam int unsigned PipeLat   = TopStages + DIV_LAT;
  localparam int unsigned LoW       = 32;
  localparam int unsigned HiW       = ROT_W - LoW;
  localparam int unsigned SumW      = 42;

  // Focal scale from the half-angle identity on the table values.
  localparam int unsigned FovC = (FOV_DEG < 10) ? 10 : ((FOV_DEG > 170) ? 170 : FOV_DEG);
  localparam logic signed [TRIG_W-1:0] FovSin = sin_deg(10'(FovC));
  localparam logic signed [TRIG_W-1:0] FovCos = cos_deg(ANG_W'(FovC));
  localparam longint FocalNum = longint'(SCREEN_H) * (longint'(16384) + longint'(FovCos))
                                * longint'(65536);
  localparam longint Focal = (FocalNum + longint'(FovSin)) / (longint'(2) * longint'(FovSin));
  localparam logic [FOCAL_W-1:0] FocalQ = FOCAL_W'(Focal);
  localparam logic signed [SumW-1:0] CenterX = SumW'(longint'(SCREEN_W) * longint'(32768));
  localparam logic signed [SumW-1:0] CenterY = SumW'(longint'(SCREEN_H) * longint'(32768));
  localparam logic signed [SumW-1:0] SatMax = SumW'(64'sd2147483647);
  localparam logic signed [SumW-1:0] SatMin = -SumW'(64'sd2147483648);
  localparam logic signed [PROD_W-1:0] RndHalf = PROD_W'(8192);

  typedef struct packed {
    logic signed [TRIG_W-1:0] sin_x;
    logic signed [TRIG_W-1:0] cos_x;
    logic signed [TRIG_W-1:0] sin_y;
    logic signed [TRIG_W-1:0] cos_y;
    logic signed [TRIG_W-1:0] sin_z;
    logic signed [TRIG_W-1:0] cos_z;
  } trig_t;

  typedef struct packed {
    logic vis;
    logic neg_x;
    logic neg_y;
  } side_t;

  // Configuration registers.
  logic signed [COORD_W-1:0] cam_x_q, cam_y_q, cam_z_q;
  logic [ANG_W-1:0]          ang_x_q, ang_y_q, ang_z_q;
  logic [DEPTH_W-1:0]        near_q, far_q;
  trig_t                     trig_q;

  // Pipeline control.
  logic               en;
  logic [PipeLat-1:0] vld_q;
  logic               out_vld_q, skid_vld_q;
  out_word_t          out_q, skid_q, tail;

  // Datapath stage registers.
  logic signed [POS_W-1:0]  s1_px_q, s1_py_q, s1_pz_q;
  logic signed [PROD_W-1:0] s2_m0_q, s2_m1_q, s2_m2_q, s2_m3_q;
  logic signed [POS_W-1:0]  s2_pz_q;
  logic signed [MID_W-1:0]  s3_a_q, s3_c2_q;
  logic signed [POS_W-1:0]  s3_pz_q;
  logic signed [PROD_W-1:0] s4_m0_q, s4_m1_q, s4_m2_q, s4_m3_q;
  logic signed [MID_W-1:0]  s4_c2_q;
  logic signed [MID_W-1:0]  s5_c1_q, s5_x_q, s5_c2_q;
  logic signed [PROD_W-1:0] s6_m0_q, s6_m1_q, s6_m2_q, s6_m3_q;
  logic signed [MID_W-1:0]  s6_x_q;
  logic signed [ROT_W-1:0]  s7_y_q, s7_z_q;
  logic signed [MID_W-1:0]  s7_x_q;
  logic [ROT_W-1:0]         s8_mag_x_q, s8_mag_y_q;
  logic [DEPTH_W-1:0]       s8_den_q, s9_den_q, s10_den_q;
  side_t                    s8_side_q, s9_side_q, s10_side_q;
  logic [LoW+FOCAL_W-1:0]   s9_lo_x_q, s9_lo_y_q;
  logic [HiW+FOCAL_W-1:0]   s9_hi_x_q, s9_hi_y_q;
  logic [NUM_W-1:0]         s10_num_x_q, s10_num_y_q;
  side_t                    div_side_q [0:DIV_LAT-1];

  // Combinational stage results.
  logic signed [PROD_W-1:0] sum_a, sum_c2, sum_c1, sum_x, sum_y, sum_z;
  logic signed [ROT_W-1:0]  x_wide;
  logic                     vis_d;
  logic [QUO_W-1:0]         quo_x, quo_y;
  logic signed [SumW-1:0]   scr_x, scr_y;

  // --------------------------------------------------------------------------
  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cam_x_q <= '0;
      cam_y_q <= '0;
      cam_z_q <= '0;
      ang_x_q <= '0;
      ang_y_q <= '0;
      ang_z_q <= '0;
      near_q  <= DEPTH_W'(65536);
      far_q   <= DEPTH_W'(65536000);
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_CAM_POS_X:   cam_x_q <= $signed(cfg_wdata_i);
        CFG_CAM_POS_Y:   cam_y_q <= $signed(cfg_wdata_i);
        CFG_CAM_POS_Z:   cam_z_q <= $signed(cfg_wdata_i);
        CFG_CAM_ANGLE_X: ang_x_q <= cfg_wdata_i[ANG_W-1:0];
        CFG_CAM_ANGLE_Y: ang_y_q <= cfg_wdata_i[ANG_W-1:0];
        CFG_CAM_ANGLE_Z: ang_z_q <= cfg_wdata_i[ANG_W-1:0];
        CFG_NEAR_DEPTH:  near_q  <= cfg_wdata_i[DEPTH_W-1:0];
        CFG_FAR_DEPTH:   far_q   <= cfg_wdata_i[DEPTH_W-1:0];
        default: ;
      endcase
    end
  end

  // Sine and cosine of the camera angles, looked up once per cycle.
  always_ff @(posedge clk_i) begin
    trig_q.sin_x <= sin_deg(10'(ang_x_q));
    trig_q.cos_x <= cos_deg(ang_x_q);
    trig_q.sin_y <= sin_deg(10'(ang_y_q));
    trig_q.cos_y <= cos_deg(ang_y_q);
    trig_q.sin_z <= sin_deg(10'(ang_z_q));
    trig_q.cos_z <= cos_deg(ang_z_q);
  end

  // --------------------------------------------------------------------------
  // The whole pipeline moves while the skid register is empty.
  assign en         = !skid_vld_q;
  assign in_stall_o = skid_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[PipeLat-2:0], in_valid_i};
    end
  end

  // Rounding of a Q.30 product sum back to Q16.16.
  always_comb begin
    sum_a  = (s2_m0_q + s2_m1_q + RndHalf) >>> 14;
    sum_c2 = (s2_m2_q - s2_m3_q + RndHalf) >>> 14;
    sum_c1 = (s4_m0_q + s4_m1_q + RndHalf) >>> 14;
    sum_x  = (s4_m2_q - s4_m3_q + RndHalf) >>> 14;
    sum_y  = (s6_m0_q + s6_m1_q + RndHalf) >>> 14;
    sum_z  = (s6_m2_q - s6_m3_q + RndHalf) >>> 14;
  end

  // Depth clip: above zero and within near and far.
  assign vis_d = !s7_z_q[ROT_W-1] && (s7_z_q != '0)
              && (s7_z_q >= $signed(ROT_W'(near_q)))
              && (s7_z_q <= $signed(ROT_W'(far_q)));
  assign x_wide = ROT_W'(s7_x_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      // Stage 1: offset from the camera.
      s1_px_q <= POS_W'(in_word_i.world_x) - POS_W'(cam_x_q);
      s1_py_q <= POS_W'(in_word_i.world_y) - POS_W'(cam_y_q);
      s1_pz_q <= POS_W'(in_word_i.world_z) - POS_W'(cam_z_q);
      // Stage 2: rotation about z, products.
      s2_m0_q <= s1_py_q * trig_q.sin_z;
      s2_m1_q <= s1_px_q * trig_q.cos_z;
      s2_m2_q <= s1_py_q * trig_q.cos_z;
      s2_m3_q <= s1_px_q * trig_q.sin_z;
      s2_pz_q <= s1_pz_q;
      // Stage 3: rotation about z, rounded.
      s3_a_q  <= MID_W'(sum_a);
      s3_c2_q <= MID_W'(sum_c2);
      s3_pz_q <= s2_pz_q;
      // Stage 4: rotation about y, products.
      s4_m0_q <= s3_pz_q * trig_q.cos_y;
      s4_m1_q <= s3_a_q * trig_q.sin_y;
      s4_m2_q <= s3_a_q * trig_q.cos_y;
      s4_m3_q <= s3_pz_q * trig_q.sin_y;
      s4_c2_q <= s3_c2_q;
      // Stage 5: rotation about y, rounded.
      s5_c1_q <= MID_W'(sum_c1);
      s5_x_q  <= MID_W'(sum_x);
      s5_c2_q <= s4_c2_q;
      // Stage 6: rotation about x, products.
      s6_m0_q <= s5_c1_q * trig_q.sin_x;
      s6_m1_q <= s5_c2_q * trig_q.cos_x;
      s6_m2_q <= s5_c1_q * trig_q.cos_x;
      s6_m3_q <= s5_c2_q * trig_q.sin_x;
      s6_x_q  <= s5_x_q;
      // Stage 7: rotation about x, rounded.
      s7_y_q  <= ROT_W'(sum_y);
      s7_z_q  <= ROT_W'(sum_z);
      s7_x_q  <= s6_x_q;
      // Stage 8: clip, magnitudes and signs.
      s8_side_q.vis   <= vis_d;
      s8_side_q.neg_x <= x_wide[ROT_W-1];
      s8_side_q.neg_y <= s7_y_q[ROT_W-1];
      s8_mag_x_q      <= x_wide[ROT_W-1] ? unsigned'(-x_wide) : unsigned'(x_wide);
      s8_mag_y_q      <= s7_y_q[ROT_W-1] ? unsigned'(-s7_y_q) : unsigned'(s7_y_q);
      s8_den_q        <= s7_z_q[DEPTH_W-1:0];
      // Stage 9: partial products with the focal scale.
      s9_lo_x_q  <= s8_mag_x_q[LoW-1:0] * FocalQ;
      s9_hi_x_q  <= s8_mag_x_q[ROT_W-1:LoW] * FocalQ;
      s9_lo_y_q  <= s8_mag_y_q[LoW-1:0] * FocalQ;
      s9_hi_y_q  <= s8_mag_y_q[ROT_W-1:LoW] * FocalQ;
      s9_side_q  <= s8_side_q;
      s9_den_q   <= s8_den_q;
      // Stage 10: full dividends.
      s10_num_x_q <= NUM_W'(s9_lo_x_q) + (NUM_W'(s9_hi_x_q) << LoW);
      s10_num_y_q <= NUM_W'(s9_lo_y_q) + (NUM_W'(s9_hi_y_q) << LoW);
      s10_side_q  <= s9_side_q;
      s10_den_q   <= s9_den_q;
      // Side information alongside the dividers.
      div_side_q[0] <= s10_side_q;
      for (int k = 1; k < DIV_LAT; k++) begin
        div_side_q[k] <= div_side_q[k-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Dividers for the column and row offsets.
  vvp_div u_div_x (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (s10_num_x_q),
    .den_i (s10_den_q),
    .quo_o (quo_x)
  );

  vvp_div u_div_y (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (s10_num_y_q),
    .den_i (s10_den_q),
    .quo_o (quo_y)
  );

  // Offset away from the screen center against the sign of the coordinate.
  assign scr_x = div_side_q[DIV_LAT-1].neg_x ? CenterX + $signed(SumW'(quo_x))
                                             : CenterX - $signed(SumW'(quo_x));
  assign scr_y = div_side_q[DIV_LAT-1].neg_y ? CenterY + $signed(SumW'(quo_y))
                                             : CenterY - $signed(SumW'(quo_y));

  function automatic logic signed [COORD_W-1:0] sat32(input logic signed [SumW-1:0] v);
    if (v > SatMax) begin
      return COORD_W'(SatMax);
    end else if (v < SatMin) begin
      return COORD_W'(SatMin);
    end
    return COORD_W'(v);
  endfunction

  always_comb begin
    tail.visible  = div_side_q[DIV_LAT-1].vis;
    tail.screen_x = div_side_q[DIV_LAT-1].vis ? sat32(scr_x) : '0;
    tail.screen_y = div_side_q[DIV_LAT-1].vis ? sat32(scr_y) : '0;
  end

  // --------------------------------------------------------------------------
  // Output register and skid register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (skid_vld_q) begin
      if (!out_stall_i) begin
        skid_vld_q <= 1'b0;
      end
    end else if (out_vld_q && out_stall_i) begin
      skid_vld_q <= vld_q[PipeLat-1];
    end else begin
      out_vld_q <= vld_q[PipeLat-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_vld_q) begin
      if (!out_stall_i) begin
        out_q <= skid_q;
      end
    end else if (out_vld_q && out_stall_i) begin
      skid_q <= tail;
    end else begin
      out_q <= tail;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_word_o  = out_q;

  // --------------------------------------------------------------------------
  // Assertions.
  a_skid_behind_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid register holds a word while the output is empty");

  a_skid_drains : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_vld_q && !out_stall_i) |=> (!skid_vld_q && out_vld_q))
    else $error("skid register did not drain into the output");

  a_hidden_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !out_q.visible) |-> (out_q.screen_x == '0 && out_q.screen_y == '0))
    else $error("clipped point carries nonzero screen coordinates");

endmodule
`default_nettype wire

### design/vvp_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Vertex view projection divider
// Pipelined restoring divider, two quotient bits per stage, with rounding
// to nearest and saturation of the quotient at 2^40.
// ----------------------------------------------------------------------------
module vvp_div (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic [vvp_pkg::NUM_W-1:0]    num_i,
  input  logic [vvp_pkg::DEPTH_W-1:0]  den_i,
  output logic [vvp_pkg::QUO_W-1:0]    quo_o
);
  import vvp_pkg::*;

  logic [DEPTH_W-1:0]  rem_q [0:DIV_STEPS];
  logic [DEPTH_W-1:0]  den_q [0:DIV_STEPS];
  logic [QUO_BITS-1:0] low_q [0:DIV_STEPS];
  logic [QUO_BITS-1:0] quo_q [0:DIV_STEPS];
  logic                big_q [0:DIV_STEPS];

  logic [DEPTH_W-1:0]  rem_d [1:DIV_STEPS];
  logic [QUO_BITS-1:0] low_d [1:DIV_STEPS];
  logic [QUO_BITS-1:0] quo_d [1:DIV_STEPS];

  logic [DEPTH_W-1:0]  head;
  logic                half_up;
  logic [QUO_W-1:0]    quo_out_q;

  // The bits above the quotient range decide saturation up front.
  assign head = DEPTH_W'(num_i[NUM_W-1:QUO_BITS]);

  // Each stage shifts in two numerator bits and subtracts where it fits.
  always_comb begin
    logic [DEPTH_W:0] trial;
    for (int k = 1; k <= DIV_STEPS; k++) begin
      rem_d[k] = rem_q[k-1];
      low_d[k] = low_q[k-1];
      quo_d[k] = quo_q[k-1];
      for (int b = 0; b < DIV_BPS; b++) begin
        trial    = {rem_d[k], low_d[k][QUO_BITS-1]};
        low_d[k] = low_d[k] << 1;
        if (trial >= {1'b0, den_q[k-1]}) begin
          rem_d[k] = DEPTH_W'(trial - {1'b0, den_q[k-1]});
          quo_d[k] = {quo_d[k][QUO_BITS-2:0], 1'b1};
        end else begin
          rem_d[k] = trial[DEPTH_W-1:0];
          quo_d[k] = {quo_d[k][QUO_BITS-2:0], 1'b0};
        end
      end
    end
  end

  // Stage registers.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= head;
      den_q[0] <= den_i;
      low_q[0] <= num_i[QUO_BITS-1:0];
      quo_q[0] <= '0;
      big_q[0] <= (head >= den_i);
      for (int k = 1; k <= DIV_STEPS; k++) begin
        rem_q[k] <= rem_d[k];
        den_q[k] <= den_q[k-1];
        low_q[k] <= low_d[k];
        quo_q[k] <= quo_d[k];
        big_q[k] <= big_q[k-1];
      end
    end
  end

  // Round half away from zero on the magnitude, then saturate.
  assign half_up = rem_q[DIV_STEPS] >= (den_q[DIV_STEPS] - rem_q[DIV_STEPS]);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (big_q[DIV_STEPS]) begin
        quo_out_q <= QUO_W'(1) << QUO_BITS;
      end else begin
        quo_out_q <= QUO_W'(quo_q[DIV_STEPS]) + QUO_W'(half_up);
      end
    end
  end

  assign quo_o = quo_out_q;

endmodule
`default_nettype wire

### dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vertex view projection unit testbench
// Streams world points through the unit under many camera settings, predicts
// each projected word in fixed point and checks the output field by field,
// with random gaps on both sides and one long output hold-off.
// ----------------------------------------------------------------------------
module tb;
  import vvp_pkg::*;

  localparam int  LIMIT   = 600000;
  localparam longint SAT40 = 64'd1 << 40;

  // Clock, reset and block ports.
  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [COORD_W-1:0]   cfg_wdata_i = '0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  in_word_t  in_word_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_word_t out_word_o;

  vertex_view_project_unit dut (.*);

  always #2 clk_i = ~clk_i;

  // Camera settings as the predictor sees them.
  longint cam_x = 0, cam_y = 0, cam_z = 0;
  int unsigned ang_x = 0, ang_y = 0, ang_z = 0;
  longint near_d = 65536, far_d = 65536000;

  in_word_t  point_q[$];
  out_word_t projected_q[$];
  int errors = 0, cycles = 0, sent = 0, seen_visible = 0, settings = 0;
  bit calm = 1'b0, took_in = 1'b0, took_out = 1'b0, offering = 1'b0;
  int gap_left = 0, wait_left = 0, hold_left = 0;

  // Sine in Q1.14 for whole degrees, folded onto the first quadrant.
  function automatic longint sine_q14(int unsigned deg);
    int unsigned d, r;
    d = deg % 360;
    r = d % 90;
    case (d / 90)
      0: return longint'(SIN_QUARTER[r]);
      1: return longint'(SIN_QUARTER[90 - r]);
      2: return -longint'(SIN_QUARTER[r]);
      default: return -longint'(SIN_QUARTER[90 - r]);
    endcase
  endfunction

  function automatic longint round14(longint v);
    return (v + 8192) >>> 14;
  endfunction

  // Focal scale from the half-angle identity, Q16.16.
  function automatic longint focal_scale();
    longint s, c;
    s = sine_q14(DEF_FOV_DEG);
    c = sine_q14(DEF_FOV_DEG + 90);
    return (longint'(DEF_SCREEN_H) * (16384 + c) * 65536 + s) / (2 * s);
  endfunction

  // Screen coordinate: center minus v*f/z, rounded, then saturated to 32 bits.
  function automatic logic [31:0] screen_coord(longint v, longint center, longint depth);
    logic [127:0] mag, quo, rem;
    longint q, r;
    mag = 128'((v < 0) ? -v : v) * 128'(focal_scale());
    quo = mag / 128'(depth);
    rem = mag % 128'(depth);
    if (quo >= 128'(SAT40)) q = SAT40;
    else begin
      q = longint'(quo) + ((2 * rem >= 128'(depth)) ? 1 : 0);
      if (q > SAT40) q = SAT40;
    end
    r = center + ((v < 0) ? q : -q);
    if (r > 64'sd2147483647) r = 64'sd2147483647;
    if (r < -64'sd2147483648) r = -64'sd2147483648;
    return r[31:0];
  endfunction

  // Camera-space transform and projection of one world point.
  function automatic out_word_t project_point(in_word_t w);
    longint px, py, pz, sx, cx, sy, cy, sz, cz, a, c1, c2, x, y, z;
    out_word_t o;
    px = longint'($signed(w.world_x)) - cam_x;
    py = longint'($signed(w.world_y)) - cam_y;
    pz = longint'($signed(w.world_z)) - cam_z;
    sx = sine_q14(ang_x); cx = sine_q14(ang_x % 360 + 90);
    sy = sine_q14(ang_y); cy = sine_q14(ang_y % 360 + 90);
    sz = sine_q14(ang_z); cz = sine_q14(ang_z % 360 + 90);
    a  = round14(sz * py + cz * px);
    c1 = round14(cy * pz + sy * a);
    c2 = round14(cz * py - sz * px);
    x  = round14(cy * a - sy * pz);
    y  = round14(sx * c1 + cx * c2);
    z  = round14(cx * c1 - sx * c2);
    o = '0;
    if (z > 0 && z >= near_d && z <= far_d) begin
      o.visible  = 1'b1;
      o.screen_x = screen_coord(x, longint'(DEF_SCREEN_W) * 32768, z);
      o.screen_y = screen_coord(y, longint'(DEF_SCREEN_H) * 32768, z);
    end
    return o;
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("mismatch on %s: got %h, expected %h", field, got, want);
  endtask

  // Input side: record accepted words and their projections.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("vertex_view_project_unit test failed");
      $finish;
    end
    if (rst_ni && in_valid_i && !in_stall_o) begin
      projected_q.push_back(project_point(in_word_i));
      took_in = 1'b1;
    end
  end

  // Output side: compare each accepted word with the oldest projection.
  always @(posedge clk_i) begin
    out_word_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      took_out = 1'b1;
      if (projected_q.size() == 0) begin
        errors++;
        $display("unexpected output word %h", out_word_o);
      end else begin
        want = projected_q.pop_front();
        if (want.visible) seen_visible++;
        if (out_word_o.visible !== want.visible)
          report_mismatch("visible", 32'(out_word_o.visible), 32'(want.visible));
        if (out_word_o.screen_x !== want.screen_x)
          report_mismatch("screen_x", out_word_o.screen_x, want.screen_x);
        if (out_word_o.screen_y !== want.screen_y)
          report_mismatch("screen_y", out_word_o.screen_y, want.screen_y);
      end
    end
  end

  // Long hold-off countdown, one step per cycle.
  always @(posedge clk_i) begin
    if (hold_left > 0) hold_left--;
  end

  // Driver: offer pending points with a random gap before each.
  always @(negedge clk_i) begin
    if (took_in) begin
      offering = 1'b0;
      took_in = 1'b0;
      gap_left = calm ? 0 : $urandom_range(0, 19);
    end
    if (!offering && point_q.size() > 0) begin
      if (gap_left > 0) gap_left--;
      else begin
        in_word_i <= point_q.pop_front();
        offering = 1'b1;
        sent++;
      end
    end
    in_valid_i <= offering;
  end

  // Receiver: random stall per word, plus the long hold-off when requested.
  always @(negedge clk_i) begin
    if (took_out) begin
      took_out = 1'b0;
      wait_left = calm ? 0 : $urandom_range(0, 19);
    end else if (wait_left > 0) wait_left--;
    out_stall_i <= (wait_left > 0) || (hold_left > 0);
  end

  task automatic write_reg(cfg_idx_e idx, logic [31:0] data);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_CAM_POS_X:   cam_x = longint'($signed(data));
      CFG_CAM_POS_Y:   cam_y = longint'($signed(data));
      CFG_CAM_POS_Z:   cam_z = longint'($signed(data));
      CFG_CAM_ANGLE_X: ang_x = data[8:0];
      CFG_CAM_ANGLE_Y: ang_y = data[8:0];
      CFG_CAM_ANGLE_Z: ang_z = data[8:0];
      CFG_NEAR_DEPTH:  near_d = longint'(data[30:0]);
      default:         far_d = longint'(data[30:0]);
    endcase
  endtask

  task automatic set_camera(logic [31:0] px, py, pz, logic [8:0] ax, ay, az,
                            logic [31:0] nr, fr);
    write_reg(CFG_CAM_POS_X, px);
    write_reg(CFG_CAM_POS_Y, py);
    write_reg(CFG_CAM_POS_Z, pz);
    write_reg(CFG_CAM_ANGLE_X, 32'(ax));
    write_reg(CFG_CAM_ANGLE_Y, 32'(ay));
    write_reg(CFG_CAM_ANGLE_Z, 32'(az));
    write_reg(CFG_NEAR_DEPTH, nr);
    write_reg(CFG_FAR_DEPTH, fr);
    settings++;
  endtask

  task automatic wait_idle();
    while (point_q.size() > 0 || offering || projected_q.size() > 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
  endtask

  function automatic in_word_t make_point(logic [31:0] x, y, z);
    in_word_t w;
    w.world_x = x; w.world_y = y; w.world_z = z;
    return w;
  endfunction

  // Mostly points within a few hundred units of the camera, some anywhere.
  function automatic logic [31:0] rand_coord(longint base);
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 7) return 32'(base + $signed(32'($urandom_range(0, 32'h3FF_FFFF))) - 32'sh200_0000);
    if (pick < 9) return $urandom;
    return ($urandom_range(0, 1) != 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
  endfunction

  task automatic queue_random(int count);
    repeat (count)
      point_q.push_back(make_point(rand_coord(cam_x), rand_coord(cam_y), rand_coord(cam_z)));
  endtask

  initial begin
    logic [31:0] nr;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset settings: depth limits, guard, saturation and field extremes.
    calm = 1'b1;
    point_q.push_back(make_point(0, 0, 32'd655360));
    point_q.push_back(make_point(0, 0, 32'd65536));
    point_q.push_back(make_point(0, 0, 32'd65535));
    point_q.push_back(make_point(0, 0, 32'd65536000));
    point_q.push_back(make_point(0, 0, 32'd65536001));
    point_q.push_back(make_point(0, 0, 0));
    point_q.push_back(make_point(0, 0, 32'hFFF0_0000));
    point_q.push_back(make_point(32'h7FFF_FFFF, 32'h8000_0000, 32'd65536));
    point_q.push_back(make_point(32'h8000_0000, 32'h7FFF_FFFF, 32'd65536));
    point_q.push_back(make_point(32'h0001_8000, 32'hFFFE_8000, 32'd131072));
    point_q.push_back(make_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    point_q.push_back(make_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    point_q.push_back(make_point(32'hFFFF_FFFF, 32'd1, 32'd3000000));
    wait_idle();
    calm = 1'b0;

    // Camera at the extremes, full depth range, angles past a full turn.
    set_camera(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 9'd359, 9'd90, 9'd511,
               32'd0, 32'h7FFF_FFFF);
    point_q.push_back(make_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    point_q.push_back(make_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0001));
    queue_random(100);
    wait_idle();
    set_camera(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 9'd180, 9'd270, 9'd360,
               32'h7FFF_FFFF, 32'h7FFF_FFFF);
    queue_random(60);
    wait_idle();

    // Near beyond far: nothing may be visible.
    set_camera(0, 0, 0, 9'd0, 9'd0, 9'd0, 32'd655360, 32'd65536);
    queue_random(40);
    wait_idle();

    // Random cameras; two phases run back to back, one against a long hold-off.
    for (int ph = 0; ph < 8; ph++) begin
      nr = $urandom_range(0, 262144);
      set_camera($urandom_range(0, 32'h7F_FFFF) - 32'h40_0000,
                 $urandom_range(0, 32'h7F_FFFF) - 32'h40_0000,
                 $urandom_range(0, 32'h7F_FFFF) - 32'h40_0000,
                 9'($urandom_range(0, 511)), 9'($urandom_range(0, 511)),
                 9'($urandom_range(0, 511)),
                 nr, nr + $urandom_range(0, 32'h7FFF_FFFF - nr));
      calm = (ph == 3) || (ph == 6);
      if (ph == 3) hold_left = 400;
      queue_random(115);
      wait_idle();
    end

    // Back to the reset depth range at the end.
    set_camera(0, 0, 0, 9'd0, 9'd0, 9'd0, 32'd65536, 32'd65536000);
    queue_random(40);
    wait_idle();
    repeat (60) @(posedge clk_i);

    $display("Projected %0d points under %0d camera settings, %0d of them visible.",
             sent, settings + 1, seen_visible);
    $display("Covered depth clipping, the zero guard, saturation and input backpressure.");
    if (errors == 0) begin
      $display("vertex_view_project_unit test passed");
    end else begin
      $display("vertex_view_project_unit test failed");
    end
    $finish;
  end

endmodule

### vertex_view_project_unit.f
design/vvp_pkg.sv
design/vvp_div.sv
design/vertex_view_project_unit.sv
dv/tb.sv
